// ===== design/fcr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcr_pkg
// Shared types and constants for the flow cache row with move-to-front order.
// ----------------------------------------------------------------------------
package fcr_pkg;

    localparam int FUNC_W = 2;
    localparam int HASH_W = 64;
    localparam int VLAN_W = 12;
    localparam int POS_W  = 4;

    localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd0;
    localparam logic [FUNC_W-1:0] FN_EMPTY  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_MOVE   = 2'd2;
    localparam logic [FUNC_W-1:0] FN_WRITE  = 2'd3;

    typedef struct packed {
        logic load;
        logic exec;
        logic emit;
    } t_cmd;

endpackage

// ===== design/fcr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcr_ctrl
// Sequencer: accept, execute, then present the result for one cycle.
// ----------------------------------------------------------------------------
module fcr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    output fcr_pkg::t_cmd o_cmd
);
    import fcr_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_RES  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = ST_RES;
            end
            ST_RES: begin
                n_state = start ? ST_EXEC : ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy       = (r_state == ST_EXEC);
    assign o_cmd.load = start && !busy;
    assign o_cmd.exec = (r_state == ST_EXEC);
    assign o_cmd.emit = (r_state == ST_RES);

`ifndef SYNTHESIS
    a_load_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.exec)
        else $error("accepted transaction not executed");
    a_exec_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> o_cmd.emit)
        else $error("execute not followed by result");
    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> $past(o_cmd.exec))
        else $error("result without execute");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.exec && o_cmd.emit))
        else $error("execute and result overlap");
`endif

endmodule

// ===== design/fcr_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcr_datapath
// Slot store, parallel compare, shift/write update and first-hit encoder.
// ----------------------------------------------------------------------------
module fcr_datapath #(
    parameter int ROW_SIZE = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fcr_pkg::t_cmd                i_cmd,
    input  logic [fcr_pkg::FUNC_W-1:0]   i_func,
    input  logic [fcr_pkg::HASH_W-1:0]   i_flow_hash,
    input  logic [fcr_pkg::VLAN_W-1:0]   i_vlan_tag,
    input  logic                         i_vlan_given,
    input  logic [fcr_pkg::POS_W-1:0]    i_source_pos,
    input  logic [fcr_pkg::POS_W-1:0]    i_target_pos,
    input  logic                         i_entry_used,
    output logic                         o_strobe,
    output logic                         o_found,
    output logic [fcr_pkg::POS_W-1:0]    o_position
);
    import fcr_pkg::*;

    localparam int IDX_W = (ROW_SIZE > 1) ? $clog2(ROW_SIZE) : 1;

    // request latched at accept
    logic [FUNC_W-1:0] r_func;
    logic [HASH_W-1:0] r_hash_q;
    logic [VLAN_W-1:0] r_vlan_q;
    logic              r_vgiven;
    logic [POS_W-1:0]  r_src;
    logic [POS_W-1:0]  r_dst;
    logic              r_used_q;

    // slot store
    logic [HASH_W-1:0] r_hash [ROW_SIZE];
    logic [VLAN_W-1:0] r_vlan [ROW_SIZE];
    logic              r_used [ROW_SIZE];
    logic [HASH_W-1:0] n_hash [ROW_SIZE];
    logic [VLAN_W-1:0] n_vlan [ROW_SIZE];
    logic              n_used [ROW_SIZE];

    logic [ROW_SIZE-1:0] r_hit;
    logic [ROW_SIZE-1:0] n_hit;
    logic                r_ok;

    logic [IDX_W-1:0] src_idx;
    logic [IDX_W-1:0] dst_idx;
    logic             src_ok;
    logic             dst_ok;
    logic             do_move;
    logic             do_write;
    logic             fwd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func   <= i_func;
            r_hash_q <= i_flow_hash;
            r_vlan_q <= i_vlan_tag;
            r_vgiven <= i_vlan_given;
            r_src    <= i_source_pos;
            r_dst    <= i_target_pos;
            r_used_q <= i_entry_used;
        end
    end

    assign src_idx  = IDX_W'(r_src);
    assign dst_idx  = IDX_W'(r_dst);
    assign src_ok   = (int'(r_src) < ROW_SIZE);
    assign dst_ok   = (int'(r_dst) < ROW_SIZE);
    assign do_move  = i_cmd.exec && (r_func == FN_MOVE) && src_ok && dst_ok
                      && (r_src != r_dst);
    assign do_write = i_cmd.exec && (r_func == FN_WRITE) && dst_ok;
    assign fwd      = (r_src < r_dst);

    always_comb begin
        for (int k = 0; k < ROW_SIZE; k++) begin
            n_hash[k] = r_hash[k];
            n_vlan[k] = r_vlan[k];
            n_used[k] = r_used[k];
            if (do_write && (k == int'(dst_idx))) begin
                n_hash[k] = r_hash_q;
                n_vlan[k] = r_vlan_q;
                n_used[k] = r_used_q;
            end else if (do_move) begin
                if (k == int'(dst_idx)) begin
                    n_hash[k] = r_hash[src_idx];
                    n_vlan[k] = r_vlan[src_idx];
                    n_used[k] = r_used[src_idx];
                end else if (fwd && (k >= int'(src_idx)) && (k < int'(dst_idx))
                             && (k < ROW_SIZE - 1)) begin
                    n_hash[k] = r_hash[(k < ROW_SIZE - 1) ? k + 1 : k];
                    n_vlan[k] = r_vlan[(k < ROW_SIZE - 1) ? k + 1 : k];
                    n_used[k] = r_used[(k < ROW_SIZE - 1) ? k + 1 : k];
                end else if (!fwd && (k > int'(dst_idx)) && (k <= int'(src_idx))
                             && (k > 0)) begin
                    n_hash[k] = r_hash[(k > 0) ? k - 1 : k];
                    n_vlan[k] = r_vlan[(k > 0) ? k - 1 : k];
                    n_used[k] = r_used[(k > 0) ? k - 1 : k];
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < ROW_SIZE; k++) begin
            if (r_func == FN_LOOKUP) begin
                n_hit[k] = r_used[k] && (r_hash[k] == r_hash_q)
                           && (!r_vgiven || (r_vlan[k] == r_vlan_q));
            end else begin
                n_hit[k] = !r_used[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ROW_SIZE; k++) begin
                r_hash[k] <= '0;
                r_vlan[k] <= '0;
                r_used[k] <= 1'b0;
            end
        end else begin
            for (int k = 0; k < ROW_SIZE; k++) begin
                r_hash[k] <= n_hash[k];
                r_vlan[k] <= n_vlan[k];
                r_used[k] <= n_used[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_hit <= n_hit;
            r_ok  <= (r_func == FN_MOVE) ? (src_ok && dst_ok) : dst_ok;
        end
    end

    logic [POS_W-1:0] first_pos;

    always_comb begin
        first_pos = '0;
        for (int k = ROW_SIZE - 1; k >= 0; k--) begin
            if (r_hit[k]) first_pos = POS_W'(k);
        end
    end

    assign o_strobe = i_cmd.emit;

    always_comb begin
        case (r_func)
            FN_LOOKUP, FN_EMPTY: begin
                o_found    = |r_hit;
                o_position = first_pos;
            end
            default: begin
                o_found    = r_ok;
                o_position = '0;
            end
        endcase
    end

endmodule

// ===== design/flow_cache_row_mtf_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_cache_row_mtf_top
// One flow cache row kept in move-to-front order: lookup, empty search,
// move and write on a row of ROW_SIZE slots.
// ----------------------------------------------------------------------------
// The accepting edge enters the single execute state (compare and shift);
// the result state with the result strobe follows it. start may be held
// through the result cycle, since a new transaction is accepted there too.
// busy is high only in the execute cycle; results cannot be stalled.
// Reset (synchronous, active low) clears all slots and returns to idle.
module flow_cache_row_mtf_top #(
    parameter int ROW_SIZE = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [fcr_pkg::FUNC_W-1:0]   i_func,
    input  logic [fcr_pkg::HASH_W-1:0]   i_flow_hash,
    input  logic [fcr_pkg::VLAN_W-1:0]   i_vlan_tag,
    input  logic                         i_vlan_given,
    input  logic [fcr_pkg::POS_W-1:0]    i_source_pos,
    input  logic [fcr_pkg::POS_W-1:0]    i_target_pos,
    input  logic                         i_entry_used,
    output logic                         o_strobe,
    output logic                         o_found,
    output logic [fcr_pkg::POS_W-1:0]    o_position
);
    import fcr_pkg::*;

    t_cmd cmd;

    fcr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    fcr_datapath #(
        .ROW_SIZE (ROW_SIZE)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_func       (i_func),
        .i_flow_hash  (i_flow_hash),
        .i_vlan_tag   (i_vlan_tag),
        .i_vlan_given (i_vlan_given),
        .i_source_pos (i_source_pos),
        .i_target_pos (i_target_pos),
        .i_entry_used (i_entry_used),
        .o_strobe     (o_strobe),
        .o_found      (o_found),
        .o_position   (o_position)
    );

endmodule
